>>> design/smartcard_atr_framer_unit_defines.svh
// assertion macros for the smartcard atr framer checker
// no dependencies; included by the checker file only
`ifndef SMARTCARD_ATR_FRAMER_UNIT_DEFINES_SVH
`define SMARTCARD_ATR_FRAMER_UNIT_DEFINES_SVH

// clocked assertion, held off while reset is low
`define SCAF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SCAF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/scaf_pkg.sv
// shared types, codes and constants of the smartcard atr framer
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps

package scaf_pkg;

    localparam int RECEIVE_LIMIT_DEF = 96;
    localparam int CNT_W             = 7;

    localparam logic [7:0] TS_DIRECT  = 8'h3B;
    localparam logic [7:0] TS_INVERSE = 8'h3F;

    // phase codes as shown on the result beat
    localparam logic [1:0] PHASE_HUNT  = 2'd0;
    localparam logic [1:0] PHASE_RECV  = 2'd1;
    localparam logic [1:0] PHASE_DONE  = 2'd2;
    localparam logic [1:0] PHASE_LIMIT = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_RECV  = 4'b0010,
        PH_DONE  = 4'b0100,
        PH_LIMIT = 4'b1000
    } t_phase;

    typedef enum logic [3:0] {
        ST_T0    = 4'b0001,
        ST_IFACE = 4'b0010,
        ST_HIST  = 4'b0100,
        ST_TCK   = 4'b1000
    } t_stage;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic             in_atr;
        logic [CNT_W-1:0] atr_index;
        logic [1:0]       phase;
        logic             tck_expected;
    } t_out_item;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_HUNT:  code = PHASE_HUNT;
            PH_RECV:  code = PHASE_RECV;
            PH_DONE:  code = PHASE_DONE;
            PH_LIMIT: code = PHASE_LIMIT;
            default:  code = PHASE_HUNT;
        endcase
        return code;
    endfunction

endpackage

>>> design/smartcard_atr_framer_unit.sv
// top level of the smartcard answer-to-reset framer
// depends on scaf_pkg for beat types, phase codes and constants
`timescale 1ns / 1ps

// usage
//   input channel: i_in_valid / o_in_ready / i_in_data, one beat per byte
//   received from the card, or a restart beat (mode = 1) that clears the
//   whole framing state at the start of a new reset attempt
//   output channel: o_out_valid / i_out_ready / o_out_data, exactly one
//   result beat for each input beat, in order
// latency and throughput
//   a result is registered in the cycle after its input beat is taken; one beat per
//   cycle is sustained while results are taken, set by the single per-byte state
//   update that sits between the framing state registers and the result register
// reset
//   i_rst_n low (synchronous) puts the framer in ts hunting with all counts
//   at zero and empties the result register
// stall
//   while a result waits, the next beat is still taken if the receiver
//   takes the waiting one in the same cycle; otherwise o_in_ready drops
//   and the state holds until the result register frees up
// limit
//   every byte since the restart counts toward RECEIVE_LIMIT; reaching it
//   before the atr is complete freezes the framer in the limit phase

module smartcard_atr_framer_unit #(
    parameter int RECEIVE_LIMIT = scaf_pkg::RECEIVE_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  scaf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output scaf_pkg::t_out_item o_out_data
);

    localparam int CW = scaf_pkg::CNT_W;

    // framing state
    scaf_pkg::t_phase r_phase, n_phase;
    scaf_pkg::t_stage r_stage, n_stage;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_len, n_len;
    logic [3:0]       r_pend, n_pend;
    logic [3:0]       r_hist, n_hist;
    logic             r_chk, n_chk;

    // result register
    logic                r_out_valid;
    scaf_pkg::t_out_item r_out_data;
    scaf_pkg::t_out_item n_out_data;

    logic       in_fire;
    logic [7:0] b;
    logic       taken;
    logic [CW-1:0] index;
    // field values right after the byte is folded in, before stage choice
    logic [3:0] f_pend;
    logic [3:0] f_hist;
    logic       f_chk;
    logic       do_advance;

    // the result register frees when empty or when its beat leaves now
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign b          = i_in_data.rx_byte;

    always_comb begin
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_count    = r_count;
        n_len      = r_len;
        n_pend     = r_pend;
        n_hist     = r_hist;
        n_chk      = r_chk;
        taken      = 1'b0;
        index      = '0;
        f_pend     = r_pend;
        f_hist     = r_hist;
        f_chk      = r_chk;
        do_advance = 1'b0;

        if (i_in_data.mode) begin
            // restart attempt: everything back to hunting
            n_phase = scaf_pkg::PH_HUNT;
            n_stage = scaf_pkg::ST_T0;
            n_count = '0;
            n_len   = '0;
            n_pend  = '0;
            n_hist  = '0;
            n_chk   = 1'b0;
        end else if (r_phase == scaf_pkg::PH_HUNT || r_phase == scaf_pkg::PH_RECV) begin
            n_count = r_count + 1'b1;
            if (r_phase == scaf_pkg::PH_HUNT) begin
                if (b == scaf_pkg::TS_DIRECT || b == scaf_pkg::TS_INVERSE) begin
                    taken   = 1'b1;
                    n_len   = CW'(1);
                    n_stage = scaf_pkg::ST_T0;
                    n_phase = scaf_pkg::PH_RECV;
                end
            end else begin
                taken = 1'b1;
                index = r_len;
                n_len = r_len + 1'b1;
                unique case (r_stage)
                    scaf_pkg::ST_T0: begin
                        // indicator nibble and historical count
                        f_pend     = b[7:4];
                        f_hist     = b[3:0];
                        do_advance = 1'b1;
                    end
                    scaf_pkg::ST_IFACE: begin
                        // ta, tb, tc in that order; otherwise this is td
                        priority if (r_pend[0]) begin
                            f_pend = r_pend & 4'b1110;
                        end else if (r_pend[1]) begin
                            f_pend = r_pend & 4'b1101;
                        end else if (r_pend[2]) begin
                            f_pend = r_pend & 4'b1011;
                        end else begin
                            f_pend = b[7:4];
                            if (b[3:0] != 4'h0) begin
                                f_chk = 1'b1;
                            end
                        end
                        do_advance = 1'b1;
                    end
                    scaf_pkg::ST_HIST: begin
                        if (r_hist != 4'h0) begin
                            f_hist = r_hist - 1'b1;
                        end
                        if (f_hist == 4'h0) begin
                            if (r_chk) begin
                                n_stage = scaf_pkg::ST_TCK;
                            end else begin
                                n_phase = scaf_pkg::PH_DONE;
                            end
                        end
                    end
                    scaf_pkg::ST_TCK: begin
                        n_phase = scaf_pkg::PH_DONE;
                    end
                    default: begin
                        n_phase = scaf_pkg::PH_DONE;
                    end
                endcase
                n_pend = f_pend;
                n_hist = f_hist;
                n_chk  = f_chk;
                if (do_advance) begin
                    priority if (f_pend != 4'h0) begin
                        n_stage = scaf_pkg::ST_IFACE;
                    end else if (f_hist != 4'h0) begin
                        n_stage = scaf_pkg::ST_HIST;
                    end else if (f_chk) begin
                        n_stage = scaf_pkg::ST_TCK;
                    end else begin
                        n_phase = scaf_pkg::PH_DONE;
                    end
                end
            end
            // completion on the last allowed byte wins over the limit
            if (n_phase != scaf_pkg::PH_DONE && n_count >= CW'(RECEIVE_LIMIT)) begin
                n_phase = scaf_pkg::PH_LIMIT;
            end
        end

        n_out_data.in_atr       = taken;
        n_out_data.atr_index    = index;
        n_out_data.phase        = scaf_pkg::phase_code(n_phase);
        n_out_data.tck_expected = n_chk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= scaf_pkg::PH_HUNT;
            r_stage     <= scaf_pkg::ST_T0;
            r_count     <= '0;
            r_len       <= '0;
            r_pend      <= '0;
            r_hist      <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_stage <= n_stage;
                r_count <= n_count;
                r_len   <= n_len;
                r_pend  <= n_pend;
                r_hist  <= n_hist;
                r_chk   <= n_chk;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> design/scaf_checker.sv
// port-level checks for the smartcard atr framer, bound to the top level
// depends on scaf_pkg and smartcard_atr_framer_unit_defines.svh
`timescale 1ns / 1ps
`include "smartcard_atr_framer_unit_defines.svh"

module scaf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input scaf_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input scaf_pkg::t_out_item o_out_data
);

    `SCAF_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "stalled result beat changed")
    `SCAF_ASSERT_ALWAYS(a_ready_when_empty, i_rst_n && !o_out_valid |-> o_in_ready, "input stalled with empty result register")
    `SCAF_ASSERT(a_restart_zero, i_in_valid && o_in_ready && i_in_data.mode |=> o_out_valid && o_out_data == '0, "restart beat gave a nonzero result")
    `SCAF_ASSERT(a_atr_phase, o_out_valid && o_out_data.in_atr |-> o_out_data.phase != scaf_pkg::PHASE_HUNT, "atr byte taken while still hunting")
    `SCAF_ASSERT(a_index_zero, o_out_valid && !o_out_data.in_atr |-> o_out_data.atr_index == '0, "index set on a byte outside the atr")

endmodule

bind smartcard_atr_framer_unit scaf_checker u_scaf_checker (.*);
